[hdl/assert_macros.svh]
// Assertion macros shared by the RTL that carries concurrent checks.
// Each check is clocked on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hdl/sme_pkg.sv]
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, codes and widths of the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;

  localparam int unsigned MODE_W   = 4;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned PC_W     = 16;
  localparam int unsigned STATUS_W = 3;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Opcodes; codes above OP_NOP behave as a no-op.
  localparam mode_t OP_PUSH  = 4'd0;
  localparam mode_t OP_POP   = 4'd1;
  localparam mode_t OP_ADD   = 4'd2;
  localparam mode_t OP_MUL   = 4'd3;
  localparam mode_t OP_SWAP  = 4'd4;
  localparam mode_t OP_JNZ   = 4'd5;
  localparam mode_t OP_JMP   = 4'd6;
  localparam mode_t OP_PRINT = 4'd7;
  localparam mode_t OP_DUP   = 4'd8;
  localparam mode_t OP_EXIT  = 4'd9;
  localparam mode_t OP_NOP   = 4'd10;

  localparam status_t ST_RUN   = 3'd0;
  localparam status_t ST_END   = 3'd1;
  localparam status_t ST_EXIT  = 3'd2;
  localparam status_t ST_UNDER = 3'd3;
  localparam status_t ST_OVER  = 3'd4;
  localparam status_t ST_BADJ  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL2,
    S_MUL3,
    S_MULC,
    S_SWAP2
  } state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_step_t;

  typedef struct packed {
    logic      latch;
    logic      commit;
    mul_step_t mul_step;
    logic      wr_second;
  } sme_cmd_t;

  typedef struct packed {
    logic fault;
    logic is_mul;
    logic is_swap;
    logic halted;
  } sme_sts_t;

endpackage

[hdl/sme_instr_if.sv]
// ----------------------------------------------------------------------------
// sme_instr_if
// Instruction channel: one word carries an opcode and its operand.
// ----------------------------------------------------------------------------
interface sme_instr_if;
  import sme_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [WORD_W-1:0] operand;

  modport source (output valid, output mode, output operand, input ready);
  modport sink   (input valid, input mode, input operand, output ready);
endinterface

[hdl/sme_result_if.sv]
// ----------------------------------------------------------------------------
// sme_result_if
// Result channel: next fetch index, print data and machine status.
// ----------------------------------------------------------------------------
interface sme_result_if;
  import sme_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic                     print_valid;
  logic                     print_as_char;
  logic signed [WORD_W-1:0] print_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output next_pc, output print_valid, output print_as_char,
                  output print_value, output status, input ready);
  modport sink   (input valid, input next_pc, input print_valid, input print_as_char,
                  input print_value, input status, output ready);
endinterface

[hdl/sme_ram.sv]
// ----------------------------------------------------------------------------
// sme_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/sme_ctrl.sv]
// ----------------------------------------------------------------------------
// sme_ctrl
// Sequencer for one instruction at a time and the result valid flag.
// ----------------------------------------------------------------------------
module sme_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sme_pkg::sme_sts_t sts,
  output sme_pkg::sme_cmd_t cmd
);
  import sme_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free      = !out_valid_r || out_ready;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.latch     = 1'b0;
    cmd.commit    = 1'b0;
    cmd.mul_step  = MUL_NONE;
    cmd.wr_second = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.fault || !sts.is_mul) begin
          if (out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = (!sts.fault && sts.is_swap) ? S_SWAP2 : S_IDLE;
          end
        end else begin
          cmd.mul_step = MUL_LL;
          state_nxt    = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul_step = MUL_LH;
        state_nxt    = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_step = MUL_HL;
        state_nxt    = S_MULC;
      end
      S_MULC: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SWAP2: begin
        cmd.wr_second = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = cmd.commit || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/sme_dpath.sv]
// ----------------------------------------------------------------------------
// sme_dpath
// Machine state, stack memory, 64-bit wrapping ALU and result registers.
// ----------------------------------------------------------------------------
module sme_dpath #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sme_pkg::sme_cmd_t                cmd,
  output sme_pkg::sme_sts_t                sts,
  input  logic [sme_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [sme_pkg::WORD_W-1:0] in_operand,
  input  logic                             cfg_we,
  input  logic [sme_pkg::PC_W-1:0]         cfg_wdata,
  output logic [sme_pkg::PC_W-1:0]         out_next_pc,
  output logic                             out_print_valid,
  output logic                             out_print_as_char,
  output logic signed [sme_pkg::WORD_W-1:0] out_print_value,
  output logic [sme_pkg::STATUS_W-1:0]     out_status
);
  import sme_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  // Latched instruction.
  mode_t               mode_r;
  logic [WORD_W-1:0]   opnd_r;

  // Architectural state.
  logic [PC_W-1:0]     plen_r;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [SPW-1:0]      sp_r, sp_nxt;
  status_t             halt_r, halt_nxt;

  // Result registers.
  logic [PC_W-1:0]     npc_r, npc_nxt;
  logic                pv_r, pv_nxt;
  logic                pch_r, pch_nxt;
  logic [WORD_W-1:0]   pval_r, pval_nxt;
  status_t             st_r, st_nxt;

  // Multiplier registers.
  logic [WORD_W-1:0]   prod_r, acc_r;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [WORD_W-1:0]   mul_p, mul_res;

  // Stack memory.
  logic                we;
  logic [AW-1:0]       waddr;
  logic [WORD_W-1:0]   wdata;
  logic [SPW-1:0]      sp_m1, sp_m2;
  logic [WORD_W-1:0]   top_w, sec_w;

  // Decode and checks.
  logic is_push, is_pop, is_add, is_mul, is_swap, is_jnz, is_jmp, is_print, is_dup, is_exit;
  logic need1, need2, sp_empty, sp_lt2, sp_full, tgt_ok, take, halted, at_end;
  status_t err, fault_st;
  logic [PC_W-1:0] pc_new;

  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);

  sme_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (sp_m1[AW-1:0]),
    .raddr_b (sp_m2[AW-1:0]),
    .rdata_a (top_w),
    .rdata_b (sec_w)
  );

  always_comb begin
    is_push  = (mode_r == OP_PUSH);
    is_pop   = (mode_r == OP_POP);
    is_add   = (mode_r == OP_ADD);
    is_mul   = (mode_r == OP_MUL);
    is_swap  = (mode_r == OP_SWAP);
    is_jnz   = (mode_r == OP_JNZ);
    is_jmp   = (mode_r == OP_JMP);
    is_print = (mode_r == OP_PRINT);
    is_dup   = (mode_r == OP_DUP);
    is_exit  = (mode_r == OP_EXIT);

    need1    = is_pop || is_jnz || is_print || is_dup;
    need2    = is_add || is_mul || is_swap;
    sp_empty = (sp_r == '0);
    sp_lt2   = (sp_r < SPW'(2));
    sp_full  = (sp_r == SPW'(STACK_DEPTH));

    // A jump target is 1-based and must lie in 1..program_length.
    tgt_ok = (opnd_r[WORD_W-1:PC_W] == '0) && (opnd_r[PC_W-1:0] != '0) &&
             (opnd_r[PC_W-1:0] <= plen_r);
    take   = is_jmp || (is_jnz && (top_w != '0));

    priority if ((need1 && sp_empty) || (need2 && sp_lt2)) begin
      err = ST_UNDER;
    end else if ((is_push || is_dup) && sp_full) begin
      err = ST_OVER;
    end else if (take && !tgt_ok) begin
      err = ST_BADJ;
    end else if (is_exit) begin
      err = ST_EXIT;
    end else begin
      err = ST_RUN;
    end

    halted = (halt_r != ST_RUN);
    at_end = (pc_r >= plen_r);

    priority if (halted) begin
      fault_st = halt_r;
    end else if (at_end) begin
      fault_st = ST_END;
    end else begin
      fault_st = err;
    end

    pc_new = take ? (opnd_r[PC_W-1:0] - PC_W'(1)) : (pc_r + PC_W'(1));
  end

  assign sts.fault   = (fault_st != ST_RUN);
  assign sts.is_mul  = is_mul;
  assign sts.is_swap = is_swap;
  assign sts.halted  = halted;

  // Low 64 bits of the product from three 32x32 partial products on one
  // shared multiplier: lo*lo, then both cross terms shifted up by 32.
  always_comb begin
    unique case (cmd.mul_step)
      MUL_LL: begin
        mul_a = top_w[HALF_W-1:0];
        mul_b = sec_w[HALF_W-1:0];
      end
      MUL_LH: begin
        mul_a = top_w[HALF_W-1:0];
        mul_b = sec_w[WORD_W-1:HALF_W];
      end
      MUL_HL: begin
        mul_a = top_w[WORD_W-1:HALF_W];
        mul_b = sec_w[HALF_W-1:0];
      end
      default: begin
        mul_a = top_w[HALF_W-1:0];
        mul_b = sec_w[HALF_W-1:0];
      end
    endcase
    mul_p   = mul_a * mul_b;
    mul_res = acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step != MUL_NONE) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_step == MUL_LH) begin
      acc_r <= prod_r;
    end else if (cmd.mul_step == MUL_HL) begin
      acc_r <= mul_res;
    end
  end

  // Stack write port.
  always_comb begin
    we    = 1'b0;
    waddr = sp_r[AW-1:0];
    wdata = opnd_r;
    if (cmd.wr_second) begin
      we    = 1'b1;
      waddr = sp_m1[AW-1:0];
      wdata = sec_w;
    end else if (cmd.commit && !sts.fault) begin
      priority if (is_push) begin
        we = 1'b1;
      end else if (is_dup) begin
        we    = 1'b1;
        wdata = top_w;
      end else if (is_add) begin
        we    = 1'b1;
        waddr = sp_m2[AW-1:0];
        wdata = top_w + sec_w;
      end else if (is_mul) begin
        we    = 1'b1;
        waddr = sp_m2[AW-1:0];
        wdata = mul_res;
      end else if (is_swap) begin
        we    = 1'b1;
        waddr = sp_m2[AW-1:0];
        wdata = top_w;
      end else begin
        we = 1'b0;
      end
    end
  end

  // State and result updates at retirement.
  always_comb begin
    pc_nxt   = pc_r;
    sp_nxt   = sp_r;
    halt_nxt = halt_r;
    npc_nxt  = npc_r;
    pv_nxt   = pv_r;
    pch_nxt  = pch_r;
    pval_nxt = pval_r;
    st_nxt   = st_r;
    if (cmd.commit) begin
      if (sts.fault) begin
        halt_nxt = fault_st;
        npc_nxt  = pc_r;
        pv_nxt   = 1'b0;
        pch_nxt  = 1'b0;
        pval_nxt = '0;
        st_nxt   = fault_st;
      end else begin
        pc_nxt = pc_new;
        if (is_push || is_dup) begin
          sp_nxt = sp_r + SPW'(1);
        end else if (is_pop || is_add || is_mul) begin
          sp_nxt = sp_m1;
        end
        halt_nxt = (pc_new >= plen_r) ? ST_END : ST_RUN;
        npc_nxt  = pc_new;
        pv_nxt   = is_print;
        pch_nxt  = is_print && (opnd_r == WORD_W'(1));
        pval_nxt = is_print ? top_w : '0;
        st_nxt   = (pc_new >= plen_r) ? ST_END : ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      pc_r   <= '0;
      sp_r   <= '0;
      halt_r <= ST_RUN;
    end else begin
      if (cfg_we) begin
        plen_r <= cfg_wdata;
      end
      pc_r   <= pc_nxt;
      sp_r   <= sp_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      opnd_r <= in_operand;
    end
    npc_r  <= npc_nxt;
    pv_r   <= pv_nxt;
    pch_r  <= pch_nxt;
    pval_r <= pval_nxt;
    st_r   <= st_nxt;
  end

  assign out_next_pc       = npc_r;
  assign out_print_valid   = pv_r;
  assign out_print_as_char = pch_r;
  assign out_print_value   = pval_r;
  assign out_status        = st_r;

endmodule

[hdl/stack_machine_executor.sv]
// A word is latched when accepted in S_IDLE; its result word is registered at commit in
// S_EXEC, or for a multiply in S_MULC after S_MUL2 and S_MUL3, as its 64-bit product is
// built on one 32x32 multiplier. No new word is taken until the last commits and a swap
// does its second write on the one stack RAM write port; result-side stalls hold commit.
// Reset: synchronous, active low; clears the program counter, stack pointer, halt status,
// program length and result valid. Stack contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-machine instruction per accepted word and reports the
// next fetch index, any printed value and the sticky machine status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  sme_instr_if.sink                in_if,
  sme_result_if.source             out_if,
  input  logic                     cfg_we,
  input  logic [sme_pkg::PC_W-1:0] cfg_wdata
);
  import sme_pkg::*;

  // The controller sequences each instruction: it takes the word, lets the
  // stack RAM deliver the two top entries, runs the multiplier steps when
  // needed and then commits. Commit waits until the result register is free,
  // so a finished result can sit while the next word is already taken.
  sme_cmd_t cmd;
  sme_sts_t sts;

  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the program counter, stack pointer, halt status and
  // program length, the stack RAM, the adder and the shared multiplier, and
  // the result word registers.
  sme_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_if.mode),
    .in_operand        (in_if.operand),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_next_pc       (out_if.next_pc),
    .out_print_valid   (out_if.print_valid),
    .out_print_as_char (out_if.print_as_char),
    .out_print_value   (out_if.print_value),
    .out_status        (out_if.status)
  );

  // One instruction at a time: after a word is taken, input is closed.
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)

  // A commit never overwrites a result word that has not been taken.
  `ASSERT_SAME(a_commit_free, clk, rst_n, cmd.commit, !out_if.valid || out_if.ready)

  // A delivered halting status implies the machine is halted.
  `ASSERT_SAME(a_halt_sticky, clk, rst_n,
               out_if.valid && out_if.ready && (out_if.status != ST_RUN), sts.halted)

  // Multiplier steps run only for a multiply.
  `ASSERT_SAME(a_mul_only, clk, rst_n, cmd.mul_step != MUL_NONE, sts.is_mul)

endmodule
